[src/ppa_pkg.sv]
// Shared types and constants for the per-CPU page pool allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ppa_pkg;

   localparam int ADDR_W     = 39;
   localparam int CMD_W      = 2;
   localparam int CPU_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int PAGE_SHIFT = 12;
   // page number field of a 40-bit (carry-extended) address
   localparam int PG_W       = ADDR_W + 1 - PAGE_SHIFT;
   // signed difference of two addresses, one bit above the 40-bit base
   localparam int DIFF_W     = ADDR_W + 2;

   localparam logic [ADDR_W-1:0] START_RESET = 39'd2147483648;
   localparam logic [ADDR_W-1:0] LIMIT_RESET = 39'd2281701376;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_BAD_FREE = 2'd2
   } status_type;

endpackage

[src/ppa_if.sv]
// Valid/ready channel interfaces: request, response and register write.
// Depends on ppa_pkg for field widths.
`timescale 1ns / 1ps

interface ppa_req_if import ppa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CPU_W-1:0]  requester_cpu;
   logic [ADDR_W-1:0] free_addr;

   modport source (output valid, cmd, requester_cpu, free_addr, input ready);
   modport sink   (input valid, cmd, requester_cpu, free_addr, output ready);
endinterface

interface ppa_rsp_if import ppa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   page_addr;
   logic [STATUS_W-1:0] status;

   modport source (output valid, page_addr, status, input ready);
   modport sink   (input valid, page_addr, status, output ready);
endinterface

interface ppa_csr_if import ppa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[src/per_cpu_page_pool_allocator.sv]
// Per-CPU page pool allocator: per-CPU LIFO free lists of 4 KiB pages.
// Depends on ppa_pkg and the channel interfaces in ppa_if.sv.
//
//   channel  dir  beat contents                        accepted when
//   req_if   in   cmd, requester_cpu, free_addr        valid & ready
//   rsp_if   out  page_addr, status                    valid & ready
//   csr_if   in   index (0 start, 1 limit), wdata      valid & ready (ready tied high)
//
// One request at a time. Alloc steps through head pick + link read, head update
// and result load; an alloc that finds every list empty skips the link read
// and head update. Init writes one link per page.
// The link memory has no reset; every entry is written before it is read.
// Synchronous reset empties all lists and restores the region registers.
// A result waits in the output register while the next request is accepted;
// only a second finished result stalls behind an untaken one.
`timescale 1ns / 1ps

module per_cpu_page_pool_allocator import ppa_pkg::*; #(
   parameter int NUM_CPUS  = 8,
   parameter int MAX_PAGES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   ppa_req_if.sink     req_if,
   ppa_rsp_if.source   rsp_if,
   ppa_csr_if.sink     csr_if
);

   localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PW = $clog2(MAX_PAGES);
   // list heads and links hold page number plus one, zero for empty
   localparam int HW = $clog2(MAX_PAGES + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_POP,
      ST_FREE_SUB,
      ST_FREE_CHK,
      ST_INIT_SUB,
      ST_INIT_CAP,
      ST_INIT_WALK,
      ST_RESP
   } state_type;

   // requester index folded into the CPU range
   function automatic logic [CW-1:0] cpu_of(input logic [CPU_W-1:0] raw);
      logic [4:0] v;
      v = {2'b00, raw};
      for (int k = 0; k < 8; k++) begin
         if (v >= 5'(NUM_CPUS)) begin
            v = v - 5'(NUM_CPUS);
         end
      end
      return CW'(v);
   endfunction

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      start_ff, start_in;
   logic [ADDR_W-1:0]      limit_ff, limit_in;
   logic [HW-1:0]          head_ff [NUM_CPUS];
   logic [HW-1:0]          head_in [NUM_CPUS];
   logic [CW-1:0]          cpu_ff, cpu_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [CW-1:0]          tgt_ff, tgt_in;
   logic [HW-1:0]          hval_ff, hval_in;
   logic [DIFF_W-1:0]      diff_ff, diff_in;
   logic                   bad_ff, bad_in;
   logic [HW-1:0]          cnt_ff, cnt_in;
   logic [HW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          rr_ff, rr_in;
   logic [ADDR_W-1:0]      res_page_ff, res_page_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_page_ff, rsp_page_in;
   status_type             rsp_status_ff, rsp_status_in;

   // link memory: next page plus one, indexed by page number
   logic [HW-1:0]          link_mem [MAX_PAGES];
   logic [HW-1:0]          link_rd_ff;
   logic                   lk_we;
   logic [PW-1:0]          lk_waddr;
   logic [HW-1:0]          lk_wdata;
   logic                   lk_re;
   logic [PW-1:0]          lk_raddr;

   logic [PG_W-1:0]        start_pg;
   logic [PG_W+PAGE_SHIFT-1:0] base_addr;
   logic [PG_W+PAGE_SHIFT-1:0] pop_addr;
   logic [PG_W-1:0]        diff_pg;
   logic [NUM_CPUS-1:0]    nonempty;
   logic                   steal_found;
   logic [CW-1:0]          steal_idx;
   logic [CW-1:0]          tgt;
   logic [CW-1:0]          head_sel;
   logic [HW-1:0]          head_rd;
   logic [HW-1:0]          head_m1;
   logic [HW-1:0]          hval_m1;

   // page-aligned base: start rounded up, may carry into bit 39
   assign start_pg  = {1'b0, start_ff[ADDR_W-1:PAGE_SHIFT]}
                    + PG_W'(start_ff[PAGE_SHIFT-1:0] != '0);
   assign base_addr = {start_pg, {PAGE_SHIFT{1'b0}}};
   assign diff_pg   = diff_ff[DIFF_W-2:PAGE_SHIFT];
   assign hval_m1   = hval_ff - HW'(1);
   assign pop_addr  = base_addr + ((PG_W+PAGE_SHIFT)'(hval_m1) << PAGE_SHIFT);

   // lowest-numbered nonempty list, used when the requester's own is empty
   always_comb begin
      steal_found = 1'b0;
      steal_idx   = '0;
      for (int c = NUM_CPUS - 1; c >= 0; c--) begin
         nonempty[c] = (head_ff[c] != '0);
         if (head_ff[c] != '0) begin
            steal_found = 1'b1;
            steal_idx   = CW'(c);
         end
      end
   end

   assign tgt = nonempty[cpu_ff] ? cpu_ff : steal_idx;

   // single head read port, address chosen by state
   always_comb begin
      case (state_ff)
         ST_ALLOC:     head_sel = tgt;
         ST_INIT_WALK: head_sel = rr_ff;
         default:      head_sel = cpu_ff;
      endcase
   end

   assign head_rd = head_ff[head_sel];
   assign head_m1 = head_rd - HW'(1);

   // channel outputs
   assign req_if.ready     = (state_ff == ST_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.page_addr = rsp_page_ff;
   assign rsp_if.status    = rsp_status_ff;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      cpu_in        = cpu_ff;
      addr_in       = addr_ff;
      tgt_in        = tgt_ff;
      hval_in       = hval_ff;
      diff_in       = diff_ff;
      bad_in        = bad_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rr_in         = rr_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      lk_we         = 1'b0;
      lk_waddr      = '0;
      lk_wdata      = '0;
      lk_re         = 1'b0;
      lk_raddr      = '0;

      // register writes
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_START: start_in = csr_if.wdata;
            REG_LIMIT: limit_in = csr_if.wdata;
            default:   ;
         endcase
      end

      // output beat taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cpu_in  = cpu_of(req_if.requester_cpu);
               addr_in = req_if.free_addr;
               unique case (cmd_type'(req_if.cmd))
                  CMD_ALLOC: state_in = ST_ALLOC;
                  CMD_FREE:  state_in = ST_FREE_SUB;
                  CMD_INIT:  state_in = ST_INIT_SUB;
                  default: begin
                     res_page_in   = '0;
                     res_status_in = STAT_OK;
                     state_in      = ST_RESP;
                  end
               endcase
            end
         end

         // pick a list and start the link read of its top page; with every list empty, load an empty result
         ST_ALLOC: begin
            if (nonempty[cpu_ff] || steal_found) begin
               tgt_in   = tgt;
               hval_in  = head_rd;
               lk_re    = 1'b1;
               lk_raddr = head_m1[PW-1:0];
               state_in = ST_POP;
            end else begin
               res_page_in   = '0;
               res_status_in = STAT_EMPTY;
               state_in      = ST_RESP;
            end
         end

         ST_POP: begin
            head_in[tgt_ff] = link_rd_ff;
            res_page_in     = pop_addr[ADDR_W-1:0];
            res_status_in   = STAT_OK;
            state_in        = ST_RESP;
         end

         // alignment and bounds, offset from base
         ST_FREE_SUB: begin
            bad_in   = (addr_ff[PAGE_SHIFT-1:0] != '0) || (addr_ff < start_ff)
                    || (addr_ff >= limit_ff);
            diff_in  = {2'b00, addr_ff} - {1'b0, base_addr};
            state_in = ST_FREE_CHK;
         end

         ST_FREE_CHK: begin
            res_page_in = '0;
            if (bad_ff || diff_ff[DIFF_W-1] || (diff_pg >= PG_W'(MAX_PAGES))) begin
               res_status_in = STAT_BAD_FREE;
            end else begin
               lk_we           = 1'b1;
               lk_waddr        = diff_pg[PW-1:0];
               lk_wdata        = head_rd;
               head_in[cpu_ff] = HW'(diff_pg) + HW'(1);
               res_status_in   = STAT_OK;
            end
            state_in = ST_RESP;
         end

         // empty all lists, measure the region
         ST_INIT_SUB: begin
            for (int c = 0; c < NUM_CPUS; c++) begin
               head_in[c] = '0;
            end
            diff_in  = {2'b00, limit_ff} - {1'b0, base_addr};
            state_in = ST_INIT_CAP;
         end

         ST_INIT_CAP: begin
            if (diff_ff[DIFF_W-1]) begin
               cnt_in = '0;
            end else if (diff_pg >= PG_W'(MAX_PAGES)) begin
               cnt_in = HW'(MAX_PAGES);
            end else begin
               cnt_in = HW'(diff_pg);
            end
            idx_in   = '0;
            rr_in    = '0;
            state_in = ST_INIT_WALK;
         end

         // one page pushed per cycle, CPUs in turn
         ST_INIT_WALK: begin
            if (idx_ff == cnt_ff) begin
               res_page_in   = '0;
               res_status_in = STAT_OK;
               state_in      = ST_RESP;
            end else begin
               lk_we          = 1'b1;
               lk_waddr       = idx_ff[PW-1:0];
               lk_wdata       = head_rd;
               head_in[rr_ff] = idx_ff + HW'(1);
               idx_in         = idx_ff + HW'(1);
               rr_in          = (rr_ff == CW'(NUM_CPUS - 1)) ? '0 : rr_ff + CW'(1);
            end
         end

         // hand the result to the output register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= START_RESET;
         limit_ff     <= LIMIT_RESET;
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
      end
      cpu_ff        <= cpu_in;
      addr_ff       <= addr_in;
      tgt_ff        <= tgt_in;
      hval_ff       <= hval_in;
      diff_ff       <= diff_in;
      bad_ff        <= bad_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      rr_ff         <= rr_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   // link memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_waddr] <= lk_wdata;
      end
      if (lk_re) begin
         link_rd_ff <= link_mem[lk_raddr];
      end
   end

endmodule

[src/ppa_checker.sv]
// Port-level checks for the page pool allocator, bound to the top level.
// Depends on ppa_pkg and the channel interfaces in ppa_if.sv.
`timescale 1ns / 1ps

module ppa_checker import ppa_pkg::*; (
   input logic        clock,
   input logic        reset,
   ppa_req_if.sink    req_if,
   ppa_rsp_if.source  rsp_if
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.page_addr)
                                         && $stable(rsp_if.status))
      else $error("response beat changed while stalled");

   // only a successful alloc carries a page address
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status != STAT_OK) |-> rsp_if.page_addr == '0)
      else $error("error response with nonzero page address");

   // one request in flight: ready drops after every accepted beat
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while another is in flight");

   // reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

bind per_cpu_page_pool_allocator ppa_checker u_ppa_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

[sim/ppa_pool_check.sv]
// Pool checker: follows the three channels, keeps its own copy of the free
// lists and region registers, and compares each response beat in order.
// Depends on ppa_pkg and the channel interfaces in ppa_if.sv.
`timescale 1ns / 1ps

module ppa_pool_check import ppa_pkg::*; #(
   parameter int NUM_CPUS  = 8,
   parameter int MAX_PAGES = 32768
) (
   input  logic clock,
   input  logic reset,
   ppa_req_if   req_if,
   ppa_rsp_if   rsp_if,
   ppa_csr_if   csr_if,
   output int   fail_cnt,
   output int   pending_cnt
);

   // list heads hold top page + 1, so they need one value above MAX_PAGES-1
   localparam int HEAD_W = $clog2(MAX_PAGES + 1);
   localparam logic [ADDR_W:0] PAGE_MASK = (1 << PAGE_SHIFT) - 1;

   typedef struct packed {
      logic [ADDR_W-1:0] page_addr;
      status_type        status;
   } alloc_result_type;

   logic [ADDR_W-1:0] start_addr, limit_addr;
   logic [HEAD_W-1:0] pool_top [NUM_CPUS];
   logic [HEAD_W-1:0] next_page [MAX_PAGES];
   alloc_result_type  awaited_q [$];

   // first managed page: start rounded up, carry kept in the extra bit
   function automatic logic [ADDR_W:0] region_base();
      logic [ADDR_W:0] sum;
      sum = {1'b0, start_addr} + PAGE_MASK;
      return sum & ~PAGE_MASK;
   endfunction

   function automatic void push_page(int cpu, int unsigned idx);
      next_page[idx] = pool_top[cpu];
      pool_top[cpu]  = HEAD_W'(idx + 1);
   endfunction

   // returns top page + 1, or 0 when the list is empty
   function automatic int unsigned pop_page(int cpu);
      int unsigned h;
      h = pool_top[cpu];
      if (h == 0 || h > MAX_PAGES) return 0;
      pool_top[cpu] = next_page[h - 1];
      return h;
   endfunction

   // apply one request beat to the lists and return its response
   function automatic alloc_result_type serve(cmd_type cmd, logic [CPU_W-1:0] cpu,
                                              logic [ADDR_W-1:0] addr);
      alloc_result_type res;
      logic [ADDR_W:0]  base, offs, page;
      int               me, c;
      int unsigned      top;
      longint unsigned  count, idx;
      res.page_addr = '0;
      res.status    = STAT_OK;
      me   = int'(cpu) % NUM_CPUS;
      base = region_base();
      case (cmd)
         CMD_ALLOC: begin
            top = pop_page(me);
            // own list empty: steal from the lowest-numbered CPU with a page
            for (c = 0; c < NUM_CPUS && top == 0; c++)
               if (c != me) top = pop_page(c);
            if (top == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               page = base + ((ADDR_W+1)'(top - 1) << PAGE_SHIFT);
               res.page_addr = page[ADDR_W-1:0];
            end
         end
         CMD_FREE: begin
            offs = {1'b0, addr} - base;
            if (addr[PAGE_SHIFT-1:0] != '0 || addr < start_addr || addr >= limit_addr ||
                {1'b0, addr} < base || (offs >> PAGE_SHIFT) >= MAX_PAGES)
               res.status = STAT_BAD_FREE;
            else
               push_page(me, int'(offs >> PAGE_SHIFT));
         end
         CMD_INIT: begin
            for (c = 0; c < NUM_CPUS; c++) pool_top[c] = '0;
            count = 0;
            if ({1'b0, limit_addr} >= base + (1 << PAGE_SHIFT))
               count = ({1'b0, limit_addr} - base) >> PAGE_SHIFT;
            if (count > MAX_PAGES) count = MAX_PAGES;
            // deal pages round-robin, lowest page first
            for (idx = 0; idx < count; idx++)
               push_page(int'(idx % NUM_CPUS), int'(idx));
         end
         default: ;  // reserved command leaves the lists alone
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      alloc_result_type want;
      int               c;
      if (reset) begin
         start_addr = START_RESET;
         limit_addr = LIMIT_RESET;
         for (c = 0; c < NUM_CPUS; c++) pool_top[c] = '0;
         awaited_q.delete();
         fail_cnt    = 0;
         pending_cnt = 0;
      end else begin
         // register writes land before any request of the new setting
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == REG_START)
               start_addr = csr_if.wdata;
            else if (csr_if.index == REG_LIMIT)
               limit_addr = csr_if.wdata;
         end
         // compare a response beat against the oldest expectation
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_q.size() == 0) begin
               $display("%0t: response beat with none expected: page_addr %h status %0d",
                        $time, rsp_if.page_addr, rsp_if.status);
               fail_cnt++;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_if.page_addr !== want.page_addr) begin
                  $display("%0t: page_addr mismatch: expected %h, got %h",
                           $time, want.page_addr, rsp_if.page_addr);
                  fail_cnt++;
               end
               if (rsp_if.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, rsp_if.status);
                  fail_cnt++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            awaited_q.push_back(serve(cmd_type'(req_if.cmd), req_if.requester_cpu,
                                      req_if.free_addr));
         pending_cnt = awaited_q.size();
      end
   end

endmodule

[sim/tb.sv]
// Top of the allocator testbench: clock, reset, request/response/register
// stimulus and the verdict. Depends on ppa_pkg, ppa_if.sv, the allocator
// and ppa_pool_check.
`timescale 1ns / 1ps

module tb import ppa_pkg::*; ();

   localparam int NUM_CPUS   = 8;
   localparam int POOL_PAGES = 32768;
   localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
   localparam int IDLE_PCT   = 29;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

   logic              clock, reset;
   int                fail_cnt, pending_cnt;
   int                issued;      // request beats accepted so far
   logic [ADDR_W-1:0] cur_start, cur_limit;
   logic [ADDR_W:0]   cur_base;
   int                cur_pages;

   ppa_req_if req_if ();
   ppa_rsp_if rsp_if ();
   ppa_csr_if csr_if ();

   per_cpu_page_pool_allocator #(.NUM_CPUS(NUM_CPUS), .MAX_PAGES(POOL_PAGES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   ppa_pool_check #(.NUM_CPUS(NUM_CPUS), .MAX_PAGES(POOL_PAGES)) pool_check (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_if      (csr_if),
      .fail_cnt    (fail_cnt),
      .pending_cnt (pending_cnt)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // no idling on either side in this window of beats
   function automatic bit quiet_window();
      return issued >= 150 && issued < 300;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ADDR_W:0] round_up_page(logic [ADDR_W:0] a);
      return ((a + PAGE_BYTES - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
   endfunction

   function automatic logic [ADDR_W-1:0] page_at(int idx);
      return ADDR_W'(cur_base + ((ADDR_W+1)'(idx) << PAGE_SHIFT));
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic offer(cmd_type cmd, logic [CPU_W-1:0] cpu, logic [ADDR_W-1:0] addr);
      @(negedge clock);
      while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.cmd           <= cmd;
      req_if.requester_cpu <= cpu;
      req_if.free_addr     <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      issued++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // drain all responses, then rewrite both region registers
   task automatic set_region(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] limit);
      logic [ADDR_W:0] span;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_cnt != 0) @(negedge clock);
      write_reg(REG_START, start);
      write_reg(REG_LIMIT, limit);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      cur_start = start;
      cur_limit = limit;
      cur_base  = round_up_page({1'b0, start});
      cur_pages = 0;
      if ({1'b0, limit} >= cur_base + PAGE_BYTES) begin
         span      = ({1'b0, limit} - cur_base) >> PAGE_SHIFT;
         cur_pages = (span > POOL_PAGES) ? POOL_PAGES : int'(span);
      end
   endtask

   // small regions almost always; the first two phases hit the extremes
   task automatic choose_region(int phase);
      logic [ADDR_W-1:0] s, l;
      logic [ADDR_W:0]   sum;
      int                sel;
      sel = (phase < 2) ? phase : $urandom_range(19);
      case (sel)
         0: begin
            s = '0;
            l = '0;
         end
         1: begin
            s = ADDR_TOP;
            l = ADDR_TOP;
         end
         2: begin
            // limit below start: nothing to deal
            s = rand_addr();
            l = s >> 1;
         end
         3: begin
            s = '0;
            l = ADDR_W'(PAGE_BYTES * $urandom_range(40));
         end
         default: begin
            s = rand_addr();
            if ($urandom_range(1)) s[PAGE_SHIFT-1:0] = '0;
            sum = {1'b0, s} + ((ADDR_W+1)'($urandom_range(48)) << PAGE_SHIFT) +
                  $urandom_range(PAGE_BYTES - 1);
            l = sum[ADDR_W] ? ADDR_TOP : sum[ADDR_W-1:0];
         end
      endcase
      set_region(s, l);
   endtask

   // mostly allocs and well-formed frees, some bad frees, inits and reserved
   task automatic random_item();
      logic [CPU_W-1:0]  cpu;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W:0]   up;
      int                pick, idx;
      pick = $urandom_range(99);
      cpu  = CPU_W'($urandom());
      addr = rand_addr();
      idx  = (cur_pages > 0) ? $urandom_range(cur_pages - 1) : 0;
      if (pick < 42) begin
         offer(CMD_ALLOC, cpu, addr);
      end else if (pick < 78 && cur_pages > 0) begin
         offer(CMD_FREE, cpu, page_at(idx));
      end else if (pick < 92) begin
         case ($urandom_range(3))
            0: ;
            1: addr = page_at(idx) | ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
            2: addr = cur_start - ADDR_W'(PAGE_BYTES * $urandom_range(4, 1));
            default: begin
               up   = round_up_page({1'b0, cur_limit});
               addr = ADDR_W'(up + ((ADDR_W+1)'($urandom_range(3)) << PAGE_SHIFT));
            end
         endcase
         offer(CMD_FREE, cpu, addr);
      end else if (pick < 96) begin
         offer(CMD_INIT, cpu, addr);
      end else begin
         offer(CMD_RSVD, cpu, addr);
      end
   endtask

   // response side: random stalls, one long hold-off while requests keep coming
   initial begin
      bit held;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && issued >= 400 && req_if.valid) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (120) @(negedge clock);
         end else begin
            rsp_if.ready <= quiet_window() || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   initial begin
      int c, phase, w;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.cmd           = CMD_ALLOC;
      req_if.requester_cpu = '0;
      req_if.free_addr     = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = REG_START;
      csr_if.wdata         = '0;
      issued               = 0;
      cur_start            = START_RESET;
      cur_limit            = LIMIT_RESET;
      cur_base             = {1'b0, START_RESET};
      cur_pages            = POOL_PAGES;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset region first
      offer(CMD_ALLOC, 3'd0, '0);                       // nothing dealt: empty
      offer(CMD_FREE, 3'd3, START_RESET);               // one page onto cpu 3
      offer(CMD_ALLOC, 3'd5, ADDR_TOP);                 // cpu 5 steals it
      offer(CMD_RSVD, 3'd7, ADDR_TOP);
      offer(CMD_FREE, 3'd1, START_RESET + 1);           // misaligned
      offer(CMD_FREE, 3'd1, START_RESET - PAGE_BYTES);  // below start
      offer(CMD_FREE, 3'd6, LIMIT_RESET);               // at limit
      offer(CMD_FREE, 3'd6, ADDR_TOP);
      offer(CMD_FREE, 3'd0, '0);
      offer(CMD_INIT, 3'd4, '0);                        // exactly a full pool
      for (c = 0; c < NUM_CPUS; c++)
         offer(CMD_ALLOC, CPU_W'(c), rand_addr());
      // double free pushes the same page twice
      offer(CMD_FREE, 3'd2, LIMIT_RESET - PAGE_BYTES);
      offer(CMD_FREE, 3'd2, LIMIT_RESET - PAGE_BYTES);
      offer(CMD_ALLOC, 3'd2, '0);
      offer(CMD_ALLOC, 3'd2, '0);

      // whole address space: old lists read through the new base, then capped init
      set_region('0, ADDR_TOP);
      offer(CMD_ALLOC, 3'd6, '0);
      offer(CMD_INIT, 3'd0, '0);
      offer(CMD_FREE, 3'd1, ADDR_W'(POOL_PAGES) << PAGE_SHIFT);
      offer(CMD_FREE, 3'd4, ADDR_W'(POOL_PAGES - 1) << PAGE_SHIFT);
      offer(CMD_ALLOC, 3'd4, '0);

      // random phases, each with its own region
      phase = 0;
      while (issued < 680) begin
         choose_region(phase);
         if ($urandom_range(99) < 85) offer(CMD_INIT, CPU_W'($urandom()), rand_addr());
         repeat ($urandom_range(60, 25)) random_item();
         phase++;
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      for (w = 0; pending_cnt != 0 && w < 100000; w++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_cnt == 0 && pending_cnt == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
src/ppa_pkg.sv
src/ppa_if.sv
src/per_cpu_page_pool_allocator.sv
src/ppa_checker.sv
sim/ppa_pool_check.sv
sim/tb.sv
